/* src/assert_macros.svh */
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent implies consequent on the next clock edge
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/mp2d_pkg.sv */
// ----------------------------------------------------------------------------
// mp2d_pkg
// shared types and constants of the streaming max pooling core
// ----------------------------------------------------------------------------
package mp2d_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int OUT_IDX_W  = 9;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_ROWS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_COLS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_ROWS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_COLS      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_HEIGHT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_WIDTH   = 3'd7;

  // command to one axis tracker
  typedef struct packed {
    logic recalc;
    logic restart;
    logic adv;
  } axis_cmd_t;

  typedef enum logic {
    AX_CALC,
    AX_TRACK
  } axis_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RD,
    BK_WR,
    BK_END
  } back_state_t;

endpackage

/* src/max_pool_2d_stream_core.sv */
// ----------------------------------------------------------------------------
// max_pool_2d_stream_core
// streaming 2-d max pooling over column-major channel planes
// ----------------------------------------------------------------------------
//
//   channel | handshake            | beat payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_stall  | sample_value
//   out     | out_valid / out_stall| pooled_value, out_row, out_col, run_last,
//           |                      | plane_done
//   cfg     | cfg_write            | cfg_index, cfg_data
//
// the front takes a sample and, when it crosses a window boundary, stalls input
// while the window ranges catch up; at the start of a padded column or plane
// the catch-up steps over each window starting in the padding
// the back passes idle, then a read and a write state per window a sample
// touches, then an end state; the back's read-modify-write of the maxima
// memory sets the rate; after reset and after each config write the front
// works out the output counts by repeated addition of the stride; samples
// are stalled meanwhile
// a stalled output holds the back end; the 4-deep queue keeps the front going
// rst is synchronous, active high; the maxima memory is not cleared
//
module max_pool_2d_stream_core import mp2d_pkg::*; #(
  parameter int MAX_HEIGHT  = 256,
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_KERNEL  = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] sample_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SAMPLE_BITS-1:0] pooled_value,
  output logic [OUT_IDX_W-1:0]   out_row,
  output logic [OUT_IDX_W-1:0]   out_col,
  output logic                   run_last,
  output logic                   plane_done
);

  // geometry widths: positions, window indexes, signed start/end arithmetic
  localparam int R_PW = $clog2(MAX_HEIGHT);
  localparam int R_IW = $clog2(MAX_HEIGHT + 32);
  localparam int R_DW = $clog2(MAX_HEIGHT + 64) + 1;
  localparam int C_PW = $clog2(MAX_WIDTH);
  localparam int C_IW = $clog2(MAX_WIDTH + 32);
  localparam int C_DW = $clog2(MAX_WIDTH + 64) + 1;
  localparam int EW   = SAMPLE_BITS + R_PW + C_PW + 2 * R_IW + R_DW + 2 * C_IW + C_DW;
  localparam int QDEPTH = 4;

  // configuration registers
  logic [3:0] kernel_height, kernel_width, stride_rows, stride_cols;
  logic [2:0] pad_rows, pad_cols;
  logic [8:0] plane_height, plane_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_height <= 4'd2;
      kernel_width  <= 4'd2;
      stride_rows   <= 4'd2;
      stride_cols   <= 4'd2;
      pad_rows      <= 3'd0;
      pad_cols      <= 3'd0;
      plane_height  <= 9'd32;
      plane_width   <= 9'd32;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KERNEL_HEIGHT: kernel_height <= cfg_data[3:0];
        REG_KERNEL_WIDTH:  kernel_width  <= cfg_data[3:0];
        REG_STRIDE_ROWS:   stride_rows   <= cfg_data[3:0];
        REG_STRIDE_COLS:   stride_cols   <= cfg_data[3:0];
        REG_PAD_ROWS:      pad_rows      <= cfg_data[2:0];
        REG_PAD_COLS:      pad_cols      <= cfg_data[2:0];
        REG_PLANE_HEIGHT:  plane_height  <= cfg_data[8:0];
        REG_PLANE_WIDTH:   plane_width   <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // front to back queue and geometry
  logic                   q_push, q_pop, q_full, q_empty;
  logic [EW-1:0]          q_wdata, q_rdata;
  logic signed [R_DW-1:0] kh, sh, hh;
  logic signed [C_DW-1:0] kw, sw, ww;
  logic [R_IW-1:0]        ohl;
  logic [C_IW-1:0]        owl;

  // any register write restarts the plane and recomputes output counts
  mp2d_front #(
    .MAX_HEIGHT(MAX_HEIGHT), .MAX_WIDTH(MAX_WIDTH), .MAX_KERNEL(MAX_KERNEL),
    .SAMPLE_BITS(SAMPLE_BITS), .R_PW(R_PW), .R_IW(R_IW), .R_DW(R_DW),
    .C_PW(C_PW), .C_IW(C_IW), .C_DW(C_DW), .EW(EW)
  ) u_front (
    .clk(clk), .rst(rst), .recalc(cfg_write),
    .kernel_height(kernel_height), .kernel_width(kernel_width),
    .stride_rows(stride_rows), .stride_cols(stride_cols),
    .pad_rows(pad_rows), .pad_cols(pad_cols),
    .plane_height(plane_height), .plane_width(plane_width),
    .in_valid(in_valid), .in_stall(in_stall), .sample_value(sample_value),
    .q_full(q_full), .q_push(q_push), .q_data(q_wdata),
    .kh(kh), .sh(sh), .hh(hh), .ohl(ohl),
    .kw(kw), .sw(sw), .ww(ww), .owl(owl)
  );

  mp2d_fifo #(
    .WIDTH(EW), .DEPTH(QDEPTH)
  ) u_queue (
    .clk(clk), .rst(rst),
    .push(q_push), .wdata(q_wdata),
    .pop(q_pop), .rdata(q_rdata),
    .full(q_full), .empty(q_empty)
  );

  // back end owns the maxima memory and the output register
  mp2d_back #(
    .MAX_KERNEL(MAX_KERNEL), .SAMPLE_BITS(SAMPLE_BITS),
    .R_PW(R_PW), .R_IW(R_IW), .R_DW(R_DW),
    .C_PW(C_PW), .C_IW(C_IW), .C_DW(C_DW), .EW(EW)
  ) u_back (
    .clk(clk), .rst(rst),
    .q_empty(q_empty), .q_data(q_rdata), .q_pop(q_pop),
    .kh(kh), .sh(sh), .hh(hh), .ohl(ohl),
    .kw(kw), .sw(sw), .ww(ww), .owl(owl),
    .out_valid(out_valid), .out_stall(out_stall),
    .pooled_value(pooled_value), .out_row(out_row), .out_col(out_col),
    .run_last(run_last), .plane_done(plane_done)
  );

endmodule

/* src/mp2d_axis.sv */
// ----------------------------------------------------------------------------
// mp2d_axis
// tracks one plane dimension: position and range of windows covering it
// ----------------------------------------------------------------------------
module mp2d_axis import mp2d_pkg::*; #(
  parameter int NMAX = 256,
  parameter int MAXK = 8,
  parameter int PW   = 8,
  parameter int IW   = 9,
  parameter int DW   = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  axis_cmd_t            cmd,
  input  logic [3:0]           k_raw,
  input  logic [3:0]           s_raw,
  input  logic [2:0]           p_raw,
  input  logic [8:0]           n_raw,
  output logic [PW-1:0]        pos,
  output logic [IW-1:0]        first,
  output logic [IW-1:0]        last,
  output logic [IW-1:0]        olast,
  output logic signed [DW-1:0] first_start,
  output logic signed [DW-1:0] k,
  output logic signed [DW-1:0] s,
  output logic signed [DW-1:0] n,
  output logic                 at_end,
  output logic                 busy
);

  axis_state_t          state, state_next;
  logic [IW-1:0]        cnt;
  logic signed [DW-1:0] acc;
  logic signed [DW-1:0] fst_end;
  logic signed [DW-1:0] nxt;
  logic signed [DW-1:0] p;
  logic signed [DW-1:0] num;
  logic signed [DW-1:0] numc;
  logic signed [DW-1:0] pos_s;
  logic                 first_step;
  logic                 last_step;
  logic                 calc_done;

  // saturated geometry
  always_comb begin
    if (k_raw == 4'd0) begin
      k = DW'(1);
    end else if (DW'(k_raw) > DW'(MAXK)) begin
      k = DW'(MAXK);
    end else begin
      k = DW'(k_raw);
    end
    s = (s_raw == 4'd0) ? DW'(1) : DW'(s_raw);
    p = (DW'(p_raw) > k - DW'(1)) ? k - DW'(1) : DW'(p_raw);
    if (n_raw == 9'd0) begin
      n = DW'(1);
    end else if (DW'(n_raw) > DW'(NMAX)) begin
      n = DW'(NMAX);
    end else begin
      n = DW'(n_raw);
    end
    num  = n + (p <<< 1) - k;
    numc = (num < 0) ? DW'(0) : num;
  end

  assign pos_s       = signed'(DW'(pos));
  assign first_step  = (state == AX_TRACK) && (pos_s > fst_end);
  assign last_step   = (state == AX_TRACK) && (last < olast) && (nxt <= pos_s);
  assign busy        = (state == AX_CALC) || first_step || last_step;
  assign at_end      = (pos_s == n - DW'(1));
  assign first_start = fst_end - (k - DW'(1));
  assign calc_done   = (acc >= numc);

  always_comb begin
    state_next = state;
    if (cmd.recalc) begin
      state_next = AX_CALC;
    end else begin
      case (state)
        AX_CALC:  if (calc_done) state_next = AX_TRACK;
        AX_TRACK: state_next = AX_TRACK;
        default:  state_next = AX_CALC;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= AX_CALC;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.recalc) begin
      cnt     <= '0;
      acc     <= '0;
      pos     <= '0;
      first   <= '0;
      last    <= '0;
      fst_end <= '0;
      nxt     <= '0;
    end else if (state == AX_CALC) begin
      if (calc_done) begin
        // last output index from the ceiling formula, minus a window starting in padding
        olast   <= (acc - p >= n) ? cnt - 1'b1 : cnt;
        pos     <= '0;
        first   <= '0;
        last    <= '0;
        fst_end <= k - DW'(1) - p;
        nxt     <= s - p;
      end else begin
        cnt <= cnt + 1'b1;
        acc <= acc + s;
      end
    end else if (cmd.restart) begin
      pos     <= '0;
      first   <= '0;
      last    <= '0;
      fst_end <= k - DW'(1) - p;
      nxt     <= s - p;
    end else if (cmd.adv) begin
      pos <= pos + 1'b1;
    end else begin
      if (first_step) begin
        first   <= first + 1'b1;
        fst_end <= fst_end + s;
      end
      if (last_step) begin
        last <= last + 1'b1;
        nxt  <= nxt + s;
      end
    end
  end

endmodule

/* src/mp2d_fifo.sv */
// ----------------------------------------------------------------------------
// mp2d_fifo
// short queue between the classifying front and the window back end
// ----------------------------------------------------------------------------
module mp2d_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW:0]      wptr;
  logic [AW:0]      rptr;

  assign empty = (wptr == rptr);
  assign full  = (wptr[AW] != rptr[AW]) && (wptr[AW-1:0] == rptr[AW-1:0]);
  assign rdata = mem[rptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
    end else begin
      if (push && !full) begin
        wptr <= wptr + 1'b1;
      end
      if (pop && !empty) begin
        rptr <= rptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wptr[AW-1:0]] <= wdata;
    end
  end

endmodule

/* src/mp2d_front.sv */
// ----------------------------------------------------------------------------
// mp2d_front
// accepts samples and tags each with its plane position and window ranges
// ----------------------------------------------------------------------------
module mp2d_front import mp2d_pkg::*; #(
  parameter int MAX_HEIGHT  = 256,
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_KERNEL  = 8,
  parameter int SAMPLE_BITS = 16,
  parameter int R_PW = 8,
  parameter int R_IW = 9,
  parameter int R_DW = 10,
  parameter int C_PW = 8,
  parameter int C_IW = 9,
  parameter int C_DW = 10,
  parameter int EW   = 100
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   recalc,
  input  logic [3:0]             kernel_height,
  input  logic [3:0]             kernel_width,
  input  logic [3:0]             stride_rows,
  input  logic [3:0]             stride_cols,
  input  logic [2:0]             pad_rows,
  input  logic [2:0]             pad_cols,
  input  logic [8:0]             plane_height,
  input  logic [8:0]             plane_width,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] sample_value,
  input  logic                   q_full,
  output logic                   q_push,
  output logic [EW-1:0]          q_data,
  output logic signed [R_DW-1:0] kh,
  output logic signed [R_DW-1:0] sh,
  output logic signed [R_DW-1:0] hh,
  output logic [R_IW-1:0]        ohl,
  output logic signed [C_DW-1:0] kw,
  output logic signed [C_DW-1:0] sw,
  output logic signed [C_DW-1:0] ww,
  output logic [C_IW-1:0]        owl
);

  axis_cmd_t             row_cmd, col_cmd;
  logic [R_PW-1:0]       r_pos;
  logic [R_IW-1:0]       r_first, r_last;
  logic signed [R_DW-1:0] r_start;
  logic                  r_end, r_busy;
  logic [C_PW-1:0]       c_pos;
  logic [C_IW-1:0]       c_first, c_last;
  logic signed [C_DW-1:0] c_start;
  logic                  c_end, c_busy;
  logic                  accept;

  assign in_stall = q_full || r_busy || c_busy;
  assign accept   = in_valid && !in_stall;
  assign q_push   = accept;

  // row index runs fastest, wrap carries into the column
  always_comb begin
    row_cmd.recalc  = recalc;
    row_cmd.restart = accept && r_end;
    row_cmd.adv     = accept && !r_end;
    col_cmd.recalc  = recalc;
    col_cmd.restart = accept && r_end && c_end;
    col_cmd.adv     = accept && r_end && !c_end;
  end

  assign q_data = {sample_value, r_pos, c_pos, r_first, r_last, r_start,
                   c_first, c_last, c_start};

  mp2d_axis #(
    .NMAX(MAX_HEIGHT), .MAXK(MAX_KERNEL), .PW(R_PW), .IW(R_IW), .DW(R_DW)
  ) u_row (
    .clk(clk), .rst(rst), .cmd(row_cmd),
    .k_raw(kernel_height), .s_raw(stride_rows), .p_raw(pad_rows), .n_raw(plane_height),
    .pos(r_pos), .first(r_first), .last(r_last), .olast(ohl), .first_start(r_start),
    .k(kh), .s(sh), .n(hh), .at_end(r_end), .busy(r_busy)
  );

  mp2d_axis #(
    .NMAX(MAX_WIDTH), .MAXK(MAX_KERNEL), .PW(C_PW), .IW(C_IW), .DW(C_DW)
  ) u_col (
    .clk(clk), .rst(rst), .cmd(col_cmd),
    .k_raw(kernel_width), .s_raw(stride_cols), .p_raw(pad_cols), .n_raw(plane_width),
    .pos(c_pos), .first(c_first), .last(c_last), .olast(owl), .first_start(c_start),
    .k(kw), .s(sw), .n(ww), .at_end(c_end), .busy(c_busy)
  );

endmodule

/* src/mp2d_back.sv */
// ----------------------------------------------------------------------------
// mp2d_back
// walks the windows of each sample, updates running maxima, emits results
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mp2d_back import mp2d_pkg::*; #(
  parameter int MAX_KERNEL  = 8,
  parameter int SAMPLE_BITS = 16,
  parameter int R_PW = 8,
  parameter int R_IW = 9,
  parameter int R_DW = 10,
  parameter int C_PW = 8,
  parameter int C_IW = 9,
  parameter int C_DW = 10,
  parameter int EW   = 100
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_empty,
  input  logic [EW-1:0]          q_data,
  output logic                   q_pop,
  input  logic signed [R_DW-1:0] kh,
  input  logic signed [R_DW-1:0] sh,
  input  logic signed [R_DW-1:0] hh,
  input  logic [R_IW-1:0]        ohl,
  input  logic signed [C_DW-1:0] kw,
  input  logic signed [C_DW-1:0] sw,
  input  logic signed [C_DW-1:0] ww,
  input  logic [C_IW-1:0]        owl,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SAMPLE_BITS-1:0] pooled_value,
  output logic [OUT_IDX_W-1:0]   out_row,
  output logic [OUT_IDX_W-1:0]   out_col,
  output logic                   run_last,
  output logic                   plane_done
);

  localparam int KB    = $clog2(MAX_KERNEL);
  localparam int AW    = R_IW + KB;
  localparam int DEPTH = 2 ** AW;

  back_state_t state, state_next;

  // fields of the queued beat
  logic [SAMPLE_BITS-1:0]  e_v;
  logic [R_PW-1:0]         e_r;
  logic [C_PW-1:0]         e_c;
  logic [R_IW-1:0]         e_if, e_il;
  logic signed [R_DW-1:0]  e_hs;
  logic [C_IW-1:0]         e_jf, e_jl;
  logic signed [C_DW-1:0]  e_ws;

  // current item
  logic [SAMPLE_BITS-1:0]  v;
  logic signed [R_DW-1:0]  r_s;
  logic signed [C_DW-1:0]  c_s;
  logic [R_PW-1:0]         r;
  logic [C_PW-1:0]         c;
  logic [R_IW-1:0]         ifirst, ilast, i;
  logic signed [R_DW-1:0]  istart, hs;
  logic [C_IW-1:0]         jlast, j;
  logic signed [C_DW-1:0]  ws;

  logic [SAMPLE_BITS-1:0]  mem [DEPTH];
  logic [SAMPLE_BITS-1:0]  rdata;
  logic [AW-1:0]           addr;
  logic                    rd_en, wr_en;

  logic signed [R_DW-1:0]  hs_c, he;
  logic signed [C_DW-1:0]  ws_c, we;
  logic                    touch_first, emit, can_go, out_free;
  logic [SAMPLE_BITS-1:0]  newmax;
  logic                    push_mid, push_end, empty_item;

  // pending result, released once the next one or the item end is known
  logic                    hold_valid;
  logic [SAMPLE_BITS-1:0]  hold_value;
  logic [R_IW-1:0]         hold_row;
  logic [C_IW-1:0]         hold_col;
  logic                    hold_done;

  assign {e_v, e_r, e_c, e_if, e_il, e_hs, e_jf, e_jl, e_ws} = q_data;
  assign empty_item = (e_if > e_il) || (e_jf > e_jl);

  assign r_s  = signed'(R_DW'(r));
  assign c_s  = signed'(C_DW'(c));
  assign addr = {i, j[KB-1:0]};

  always_comb begin
    hs_c = (hs < 0) ? R_DW'(0) : hs;
    he   = (hs + kh > hh) ? hh : hs + kh;
    ws_c = (ws < 0) ? C_DW'(0) : ws;
    we   = (ws + kw > ww) ? ww : ws + kw;
    touch_first = (r_s == hs_c) && (c_s == ws_c);
    newmax = (touch_first || ($signed(v) > $signed(rdata))) ? v : rdata;
    emit   = (r_s == he - R_DW'(1)) && (c_s == we - C_DW'(1));
  end

  assign out_free = !out_valid || !out_stall;
  assign can_go   = !(emit && hold_valid && !out_free);
  assign rd_en    = (state == BK_RD);
  assign wr_en    = (state == BK_WR) && can_go;
  assign push_mid = wr_en && emit && hold_valid;
  assign push_end = (state == BK_END) && hold_valid && out_free;
  assign q_pop    = (state == BK_IDLE) && !q_empty;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!q_empty) state_next = empty_item ? BK_END : BK_RD;
      end
      BK_RD: state_next = BK_WR;
      BK_WR: begin
        if (can_go) state_next = (i != ilast || j != jlast) ? BK_RD : BK_END;
      end
      BK_END: begin
        if (!hold_valid || out_free) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // window walk: row windows inner, column windows outer
  always_ff @(posedge clk) begin
    if (q_pop) begin
      v      <= e_v;
      r      <= e_r;
      c      <= e_c;
      ifirst <= e_if;
      ilast  <= e_il;
      istart <= e_hs;
      jlast  <= e_jl;
      i      <= e_if;
      hs     <= e_hs;
      j      <= e_jf;
      ws     <= e_ws;
    end else if (wr_en) begin
      if (i != ilast) begin
        i  <= i + 1'b1;
        hs <= hs + sh;
      end else if (j != jlast) begin
        j  <= j + 1'b1;
        ws <= ws + sw;
        i  <= ifirst;
        hs <= istart;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[addr];
    end
    if (wr_en) begin
      mem[addr] <= newmax;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (wr_en && emit) begin
      hold_valid <= 1'b1;
    end else if (push_end) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && emit) begin
      hold_value <= newmax;
      hold_row   <= i;
      hold_col   <= j;
      hold_done  <= (i == ohl) && (j == owl);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_mid || push_end) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_mid || push_end) begin
      pooled_value <= hold_value;
      out_row      <= OUT_IDX_W'(hold_row);
      out_col      <= OUT_IDX_W'(hold_col);
      plane_done   <= hold_done;
      run_last     <= push_end;
    end
  end

  `ASSERT_ALWAYS(a_no_rd_wr_same_cycle, !(rd_en && wr_en), "maxima read and write collide")
  `ASSERT_ALWAYS(a_push_needs_room, !((push_mid || push_end) && !out_free),
                 "result pushed over a stalled beat")
  `ASSERT_NEXT(a_hold_drained, (state == BK_END) && (state_next == BK_IDLE),
               !hold_valid, "pending result left behind at item end")

endmodule
